// File: src/sfrc_pkg.sv
`default_nettype none
package sfrc_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FRAME   = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;
	localparam logic [1:0] ST_CRC     = 2'd3;

	localparam logic [1:0] CFG_ADDR    = 2'd0;
	localparam logic [1:0] CFG_REQ     = 2'd1;
	localparam logic [1:0] CFG_REPLY   = 2'd2;
	localparam logic [1:0] CFG_TIMEOUT = 2'd3;

	localparam logic       KIND_TX   = 1'b0;
	localparam logic       KIND_DONE = 1'b1;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] SOF_BYTE  = 8'h5A;
	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] CR_BYTE   = 8'h0D;
	localparam logic [7:0] LF_BYTE   = 8'h0A;
	localparam logic [7:0] FF_BYTE   = 8'hFF;
	localparam logic [7:0] ONE_BYTE  = 8'h01;

	localparam int BC_W = 6;
	localparam logic [16:0] FRAME_OVERHEAD = 17'd12;
	localparam logic [15:0] MIN_LEN = 16'd2;

	localparam logic [BC_W-1:0] POS_SYNC    = 6'd0;
	localparam logic [BC_W-1:0] POS_ADDR    = 6'd1;
	localparam logic [BC_W-1:0] POS_TYPE    = 6'd2;
	localparam logic [BC_W-1:0] POS_CMD     = 6'd3;
	localparam logic [BC_W-1:0] POS_ZERO    = 6'd4;
	localparam logic [BC_W-1:0] POS_STAT    = 6'd5;
	localparam logic [BC_W-1:0] POS_LEN_LO  = 6'd6;
	localparam logic [BC_W-1:0] POS_LEN_HI  = 6'd7;
	localparam logic [BC_W-1:0] POS_TEMP_LO = 6'd8;
	localparam logic [BC_W-1:0] POS_TEMP_HI = 6'd9;

	localparam logic [3:0] TX_SOF    = 4'd0;
	localparam logic [3:0] TX_ADDR   = 4'd1;
	localparam logic [3:0] TX_REQ    = 4'd2;
	localparam logic [3:0] TX_CMD    = 4'd3;
	localparam logic [3:0] TX_ZERO   = 4'd4;
	localparam logic [3:0] TX_FF     = 4'd5;
	localparam logic [3:0] TX_ONE    = 4'd6;
	localparam logic [3:0] TX_PAD0   = 4'd7;
	localparam logic [3:0] TX_PAD1   = 4'd8;
	localparam logic [3:0] TX_CRC_LO = 4'd9;
	localparam logic [3:0] TX_CRC_HI = 4'd10;
	localparam logic [3:0] TX_CR     = 4'd11;
	localparam logic [3:0] TX_LF     = 4'd12;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] command;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [7:0]         tx_byte;
		logic               last;
		logic [1:0]         status;
		logic signed [15:0] temperature;
	} result_t;

	typedef struct packed {
		logic       busy;
		logic [7:0] tx_byte;
		logic       last;
	} tx_status_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: src/sensor_frame_request_and_reply_check.sv
// Channel  | Signals                                   | Direction | Moves
// item     | item_valid, item_ready, item              | in        | one item_t per handshake
// result   | result_valid, result_ready, result        | out       | one result_t per handshake
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | one register write
//
// An accepted item is registered in the input stage and is resolved there.
// A start item makes the request sequencer emit 13 result items, one per cycle at best,
// and the input stage holds the next item until the last of those bytes is in the result register.
// Received bytes and ticks leave the input stage as they are resolved; the result register lets a new item enter while
// a result waits. Reset leaves the block idle with register defaults; no clearing pass.
`default_nettype none
module sensor_frame_request_and_reply_check #(
	parameter int MAX_FRAME = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire sfrc_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output sfrc_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import sfrc_pkg::*;

	logic [7:0]  device_address_q;
	logic [7:0]  request_type_q;
	logic [7:0]  reply_type_q;
	logic [15:0] timeout_ticks_q;

	logic        valid_s1;
	item_t       item_s1;

	logic            busy_q;
	logic [BC_W-1:0] byte_count_q;
	logic [15:0]     elapsed_q;
	logic [15:0]     crc_q;
	logic [7:0]      exp_cmd_q;
	logic            header_ok_q;
	logic [15:0]     len_q;
	logic [15:0]     rx_crc_q;
	logic [15:0]     temp_q;
	logic            trailer_ok_q;

	logic            busy_n;
	logic [BC_W-1:0] byte_count_n;
	logic [15:0]     elapsed_n;
	logic [15:0]     crc_n;
	logic [7:0]      exp_cmd_n;
	logic            header_ok_n;
	logic [15:0]     len_n;
	logic [15:0]     rx_crc_n;
	logic [15:0]     temp_n;
	logic            trailer_ok_n;

	logic            res_valid;
	result_t         res;
	logic            start_c;
	logic            out_free;
	logic            fire_s1;
	logic            out_valid_q;
	result_t         out_q;
	tx_status_t      tx;

	logic [BC_W-1:0] p;
	logic [7:0]      b;
	logic [16:0]     p17;
	logic [16:0]     len17;
	logic [16:0]     total;
	logic            hdr_match;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 8'd165;
			request_type_q   <= 8'd81;
			reply_type_q     <= 8'd97;
			timeout_ticks_q  <= 16'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ADDR:    device_address_q <= cfg_data[7:0];
				CFG_REQ:     request_type_q   <= cfg_data[7:0];
				CFG_REPLY:   reply_type_q     <= cfg_data[7:0];
				CFG_TIMEOUT: timeout_ticks_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign out_free   = !out_valid_q || result_ready;
	assign fire_s1    = valid_s1 && !tx.busy && (!res_valid || out_free);
	assign item_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	assign p     = byte_count_q;
	assign b     = item_s1.rx_byte;
	assign p17   = {{(17-BC_W){1'b0}}, p};
	assign len17 = {1'b0, len_n};
	assign total = len17 + FRAME_OVERHEAD;

	always_comb begin
		case (p)
			POS_ADDR:             hdr_match = (b == device_address_q);
			POS_TYPE:             hdr_match = (b == reply_type_q);
			POS_CMD:              hdr_match = (b == exp_cmd_q);
			POS_ZERO, POS_STAT:   hdr_match = (b == 8'h00);
			default:              hdr_match = 1'b1;
		endcase
	end

	always_comb begin
		busy_n       = busy_q;
		byte_count_n = byte_count_q;
		elapsed_n    = elapsed_q;
		crc_n        = crc_q;
		exp_cmd_n    = exp_cmd_q;
		header_ok_n  = header_ok_q;
		len_n        = len_q;
		rx_crc_n     = rx_crc_q;
		temp_n       = temp_q;
		trailer_ok_n = trailer_ok_q;
		res_valid    = 1'b0;
		start_c      = 1'b0;
		res.kind        = KIND_DONE;
		res.tx_byte     = 8'h00;
		res.last        = 1'b0;
		res.status      = ST_OK;
		res.temperature = 16'sd0;

		if (item_s1.opcode == OP_START) begin
			start_c      = 1'b1;
			busy_n       = 1'b1;
			exp_cmd_n    = item_s1.command;
			byte_count_n = '0;
			elapsed_n    = 16'd0;
			crc_n        = CRC_INIT;
			header_ok_n  = 1'b1;
			len_n        = 16'd0;
			rx_crc_n     = 16'd0;
			temp_n       = 16'd0;
			trailer_ok_n = 1'b1;
		end else if (busy_q && item_s1.opcode == OP_TICK) begin
			if (elapsed_q != 16'hFFFF) begin
				elapsed_n = elapsed_q + 16'd1;
			end
			if (elapsed_n >= timeout_ticks_q) begin
				busy_n     = 1'b0;
				res_valid  = 1'b1;
				res.status = ST_TIMEOUT;
			end
		end else if (busy_q && item_s1.opcode == OP_BYTE) begin
			if (p == POS_SYNC) begin
				if (b == SYNC_BYTE) begin
					byte_count_n = POS_ADDR;
				end
			end else begin
				if (!hdr_match) begin
					header_ok_n = 1'b0;
				end
				if (p == POS_LEN_LO) begin
					len_n = {8'h00, b};
				end else if (p == POS_LEN_HI) begin
					len_n = {b, len_q[7:0]};
				end
				if (p <= POS_LEN_HI || p17 <= len17 + 17'd7) begin
					crc_n = crc_byte(crc_q, b);
				end
				if (p == POS_TEMP_LO) begin
					temp_n = {temp_q[15:8], b};
				end
				if (p == POS_TEMP_HI) begin
					temp_n = {b, temp_q[7:0]};
				end
				if (p >= POS_TEMP_LO) begin
					if (p17 == len17 + 17'd8) begin
						rx_crc_n = {rx_crc_q[15:8], b};
					end
					if (p17 == len17 + 17'd9) begin
						rx_crc_n = {b, rx_crc_q[7:0]};
					end
					if (p17 == len17 + 17'd10 && b != CR_BYTE) begin
						trailer_ok_n = 1'b0;
					end
					if (p17 == len17 + 17'd11 && b != LF_BYTE) begin
						trailer_ok_n = 1'b0;
					end
				end
				byte_count_n = p + 1'b1;
				if (p >= POS_LEN_HI) begin
					if (total > 17'(MAX_FRAME)) begin
						busy_n     = 1'b0;
						res_valid  = 1'b1;
						res.status = ST_FRAME;
					end else if (p17 + 17'd1 >= total) begin
						busy_n    = 1'b0;
						res_valid = 1'b1;
						if (!trailer_ok_n || !header_ok_n || len_n < MIN_LEN) begin
							res.status = ST_FRAME;
						end else if (rx_crc_n != 16'd0 && rx_crc_n != crc_n) begin
							res.status = ST_CRC;
						end else begin
							res.status      = ST_OK;
							res.temperature = temp_n;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			byte_count_q <= '0;
			elapsed_q    <= 16'd0;
			crc_q        <= CRC_INIT;
			exp_cmd_q    <= 8'h00;
			header_ok_q  <= 1'b1;
			len_q        <= 16'd0;
			rx_crc_q     <= 16'd0;
			temp_q       <= 16'd0;
			trailer_ok_q <= 1'b1;
		end else if (fire_s1) begin
			busy_q       <= busy_n;
			byte_count_q <= byte_count_n;
			elapsed_q    <= elapsed_n;
			crc_q        <= crc_n;
			exp_cmd_q    <= exp_cmd_n;
			header_ok_q  <= header_ok_n;
			len_q        <= len_n;
			rx_crc_q     <= rx_crc_n;
			temp_q       <= temp_n;
			trailer_ok_q <= trailer_ok_n;
		end
	end

	sfrc_tx u_tx (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (fire_s1 && start_c),
		.command        (item_s1.command),
		.device_address (device_address_q),
		.request_type   (request_type_q),
		.advance        (out_free),
		.status         (tx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= tx.busy || (fire_s1 && res_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (tx.busy) begin
				out_q.kind        <= KIND_TX;
				out_q.tx_byte     <= tx.tx_byte;
				out_q.last        <= tx.last;
				out_q.status      <= ST_OK;
				out_q.temperature <= 16'sd0;
			end else begin
				out_q <= res;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_no_fire_while_tx: assert property (@(posedge clk) disable iff (!arst_n)
		tx.busy |-> !fire_s1)
		else $error("input stage resolved an item while request bytes were pending");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_DONE |-> out_q.tx_byte == 8'h00 && !out_q.last)
		else $error("completion carries request byte fields");

	a_tx_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_TX |-> out_q.status == ST_OK
		&& out_q.temperature == 16'sd0)
		else $error("request byte carries completion fields");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> 32'(byte_count_q) < MAX_FRAME)
		else $error("byte count ran past the largest frame while busy");

	a_ok_needs_len: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && res_valid && res.status == ST_OK && res.kind == KIND_DONE
		|-> len_n >= MIN_LEN && header_ok_n && trailer_ok_n)
		else $error("success reported for a malformed frame");

endmodule
`default_nettype wire

// File: src/sfrc_tx.sv
`default_nettype none
module sfrc_tx (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [7:0]         command,
	input  wire logic [7:0]         device_address,
	input  wire logic [7:0]         request_type,
	input  wire logic               advance,
	output sfrc_pkg::tx_status_t    status
);
	import sfrc_pkg::*;

	logic        busy_q;
	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic [7:0]  cmd_q;
	logic [7:0]  byte_c;

	always_comb begin
		case (idx_q)
			TX_SOF:    byte_c = SOF_BYTE;
			TX_ADDR:   byte_c = device_address;
			TX_REQ:    byte_c = request_type;
			TX_CMD:    byte_c = cmd_q;
			TX_ZERO:   byte_c = 8'h00;
			TX_FF:     byte_c = FF_BYTE;
			TX_ONE:    byte_c = ONE_BYTE;
			TX_PAD0:   byte_c = 8'h00;
			TX_PAD1:   byte_c = 8'h00;
			TX_CRC_LO: byte_c = crc_q[7:0];
			TX_CRC_HI: byte_c = crc_q[15:8];
			TX_CR:     byte_c = CR_BYTE;
			TX_LF:     byte_c = LF_BYTE;
			default:   byte_c = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= TX_SOF;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= TX_SOF;
		end else if (busy_q && advance) begin
			if (idx_q == TX_LF) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= CRC_INIT;
			cmd_q <= command;
		end else if (busy_q && advance && idx_q >= TX_ADDR && idx_q <= TX_PAD1) begin
			crc_q <= crc_byte(crc_q, byte_c);
		end
	end

	assign status.busy    = busy_q;
	assign status.tx_byte = byte_c;
	assign status.last    = (idx_q == TX_LF);

endmodule
`default_nettype wire

// File: tb/sv/tb_sensor_frame_request_and_reply_check.sv
`default_nettype none
module tb_sensor_frame_request_and_reply_check;
	timeunit 1ns;
	timeprecision 1ps;

	import sfrc_pkg::*;

	localparam int FRAME_LIMIT = 32;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {
		FLAW_NONE,
		FLAW_ADDR,
		FLAW_TYPE,
		FLAW_CMD,
		FLAW_ZERO,
		FLAW_STATUS,
		FLAW_CR,
		FLAW_LF,
		FLAW_CRC_BAD,
		FLAW_CRC_ZERO,
		FLAW_TRUNCATE
	} reply_flaw_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Register copies and transaction state of the predictor.
	logic [7:0]  reg_device_address = 8'hA5;
	logic [7:0]  reg_request_type = 8'h51;
	logic [7:0]  reg_reply_type = 8'h61;
	logic [15:0] reg_timeout_ticks = 16'd200;
	logic        txn_busy = 1'b0;
	logic [5:0]  rx_count = '0;
	logic [15:0] tick_count = '0;
	logic [15:0] crc_acc = 16'hFFFF;
	logic [7:0]  echo_cmd = '0;
	logic        header_good = 1'b1;
	logic [15:0] length_field = '0;
	logic [15:0] crc_received = '0;
	logic [15:0] temp_raw = '0;
	logic        trailer_good = 1'b1;

	result_t awaited_results[$];
	int      error_count = 0;
	int      traffic_items = 0;
	bit      idling_on = 1'b1;
	int      stall_left = 0;

	sensor_frame_request_and_reply_check #(
		.MAX_FRAME(FRAME_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] v;
		v = acc ^ {8'h00, d};
		repeat (8) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

	function void close_transaction(input logic [1:0] st, input logic [15:0] temp);
		result_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.status = st;
		r.temperature = temp;
		awaited_results.push_back(r);
		txn_busy = 1'b0;
	endfunction

	function void predict_sensor_results(input item_t it);
		logic [7:0]  req[13];
		logic [15:0] c;
		logic [7:0]  b;
		result_t     r;
		int unsigned p;
		int unsigned len;
		int unsigned total;
		bit          ok;
		if (it.opcode == OP_START) begin
			req[0] = SOF_BYTE;
			req[1] = reg_device_address;
			req[2] = reg_request_type;
			req[3] = it.command;
			req[4] = 8'h00;
			req[5] = FF_BYTE;
			req[6] = ONE_BYTE;
			req[7] = 8'h00;
			req[8] = 8'h00;
			c = CRC_INIT;
			for (int i = 1; i <= 8; i++) begin
				c = crc16_step(c, req[i]);
			end
			req[9] = c[7:0];
			req[10] = c[15:8];
			req[11] = CR_BYTE;
			req[12] = LF_BYTE;
			for (int i = 0; i < 13; i++) begin
				r = '0;
				r.kind = KIND_TX;
				r.tx_byte = req[i];
				r.last = (i == 12);
				awaited_results.push_back(r);
			end
			echo_cmd = it.command;
			rx_count = '0;
			tick_count = '0;
			crc_acc = CRC_INIT;
			header_good = 1'b1;
			length_field = '0;
			crc_received = '0;
			temp_raw = '0;
			trailer_good = 1'b1;
			txn_busy = 1'b1;
		end else if (txn_busy && it.opcode == OP_TICK) begin
			if (tick_count != 16'hFFFF) begin
				tick_count++;
			end
			if (tick_count >= reg_timeout_ticks) begin
				close_transaction(ST_TIMEOUT, 16'h0000);
			end
		end else if (txn_busy && it.opcode == OP_BYTE) begin
			b = it.rx_byte;
			p = rx_count;
			len = length_field;
			if (p == 0) begin
				if (b == SYNC_BYTE) begin
					rx_count = 6'd1;
				end
			end else begin
				if (p <= 5) begin
					case (p)
						1: ok = (b == reg_device_address);
						2: ok = (b == reg_reply_type);
						3: ok = (b == echo_cmd);
						default: ok = (b == 8'h00);
					endcase
					if (!ok) begin
						header_good = 1'b0;
					end
				end else if (p == 6) begin
					length_field = {8'h00, b};
					len = b;
				end else if (p == 7) begin
					length_field[15:8] = b;
					len = length_field;
				end
				if (p <= 7 || p <= 7 + len) begin
					crc_acc = crc16_step(crc_acc, b);
				end
				if (p == 8) begin
					temp_raw[7:0] = b;
				end
				if (p == 9) begin
					temp_raw[15:8] = b;
				end
				if (p >= 8) begin
					if (p == 8 + len) begin
						crc_received[7:0] = b;
					end
					if (p == 9 + len) begin
						crc_received[15:8] = b;
					end
					if (p == 10 + len && b != CR_BYTE) begin
						trailer_good = 1'b0;
					end
					if (p == 11 + len && b != LF_BYTE) begin
						trailer_good = 1'b0;
					end
				end
				rx_count = 6'(p + 1);
				if (p >= 7) begin
					total = len + 12;
					if (total > FRAME_LIMIT) begin
						close_transaction(ST_FRAME, 16'h0000);
					end else if (p + 1 >= total) begin
						if (!trailer_good || !header_good || len < 2) begin
							close_transaction(ST_FRAME, 16'h0000);
						end else if (crc_received != 16'h0000 && crc_received != crc_acc) begin
							close_transaction(ST_CRC, 16'h0000);
						end else begin
							close_transaction(ST_OK, temp_raw);
						end
					end
				end
			end
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none expected, actual %p", $time, result);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				if (want.kind !== result.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time, want.kind, result.kind);
					error_count++;
				end
				if (want.tx_byte !== result.tx_byte) begin
					$display("%0t: tx_byte expected %02h actual %02h", $time, want.tx_byte,
						result.tx_byte);
					error_count++;
				end
				if (want.last !== result.last) begin
					$display("%0t: last expected %0d actual %0d", $time, want.last, result.last);
					error_count++;
				end
				if (want.status !== result.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						result.status);
					error_count++;
				end
				if (want.temperature !== result.temperature) begin
					$display("%0t: temperature expected %0d actual %0d", $time,
						want.temperature, result.temperature);
					error_count++;
				end
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic send_item(input item_t it);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		if (it.opcode == OP_START || txn_busy) begin
			traffic_items++;
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_ready !== 1'b1) @(posedge clk);
		predict_sensor_results(it);
	endtask

	task automatic send_start(input logic [7:0] cmd);
		send_item('{opcode: OP_START, command: cmd, rx_byte: 8'($urandom_range(0, 255))});
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item('{opcode: OP_BYTE, command: 8'($urandom_range(0, 255)), rx_byte: b});
	endtask

	task automatic send_tick();
		send_item('{opcode: OP_TICK, command: 8'($urandom_range(0, 255)),
			rx_byte: 8'($urandom_range(0, 255))});
	endtask

	task automatic settle_block();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] addr, input logic [7:0] req_type,
		input logic [7:0] rep_type, input logic [15:0] tmo);
		logic [1:0]  idx[4];
		logic [15:0] vals[4];
		idx = '{CFG_ADDR, CFG_REQ, CFG_REPLY, CFG_TIMEOUT};
		vals[0] = {8'($urandom_range(0, 255)), addr};
		vals[1] = {8'($urandom_range(0, 255)), req_type};
		vals[2] = {8'($urandom_range(0, 255)), rep_type};
		vals[3] = tmo;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (cfg_ready !== 1'b1) @(posedge clk);
			case (idx[i])
				CFG_ADDR: reg_device_address = vals[i][7:0];
				CFG_REQ: reg_request_type = vals[i][7:0];
				CFG_REPLY: reg_reply_type = vals[i][7:0];
				CFG_TIMEOUT: reg_timeout_ticks = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_reply(input logic [7:0] cmd, input reply_flaw_e flaw,
		input logic [15:0] len, input logic [15:0] temp, input int junk, input int tick_pct);
		logic [7:0]  frame[$];
		logic [15:0] c;
		logic [7:0]  b;
		int unsigned ln;
		int          keep;
		ln = len;
		frame = '{SYNC_BYTE, reg_device_address, reg_reply_type, cmd, 8'h00, 8'h00,
			len[7:0], len[15:8]};
		case (flaw)
			FLAW_ADDR: frame[1] ^= 8'($urandom_range(1, 255));
			FLAW_TYPE: frame[2] ^= 8'($urandom_range(1, 255));
			FLAW_CMD: frame[3] ^= 8'($urandom_range(1, 255));
			FLAW_ZERO: frame[4] = 8'($urandom_range(1, 255));
			FLAW_STATUS: frame[5] = 8'($urandom_range(1, 255));
			default: ;
		endcase
		if (ln + 12 <= FRAME_LIMIT) begin
			for (int i = 0; i < ln; i++) begin
				if (i == 0) begin
					frame.push_back(temp[7:0]);
				end else if (i == 1) begin
					frame.push_back(temp[15:8]);
				end else begin
					frame.push_back(8'($urandom_range(0, 255)));
				end
			end
			c = CRC_INIT;
			for (int i = 1; i <= 7 + ln; i++) begin
				c = crc16_step(c, frame[i]);
			end
			if (flaw == FLAW_CRC_BAD) begin
				c ^= 16'($urandom_range(1, 65535));
			end else if (flaw == FLAW_CRC_ZERO) begin
				c = 16'h0000;
			end
			frame.push_back(c[7:0]);
			frame.push_back(c[15:8]);
			frame.push_back(flaw == FLAW_CR ? CR_BYTE ^ 8'($urandom_range(1, 255)) : CR_BYTE);
			frame.push_back(flaw == FLAW_LF ? LF_BYTE ^ 8'($urandom_range(1, 255)) : LF_BYTE);
		end else begin
			repeat ($urandom_range(0, 2)) frame.push_back(8'($urandom_range(0, 255)));
		end
		if (flaw == FLAW_TRUNCATE) begin
			keep = $urandom_range(1, frame.size() - 1);
			while (frame.size() > keep) void'(frame.pop_back());
		end
		for (int i = 0; i < junk; i++) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b == SYNC_BYTE ? 8'h00 : b);
		end
		for (int i = 0; i < frame.size(); i++) begin
			if ($urandom_range(0, 99) < tick_pct) begin
				send_tick();
			end
			send_byte(frame[i]);
		end
	endtask

	task automatic test_idle_items();
		send_byte(SYNC_BYTE);
		send_tick();
		send_item('{opcode: OP_UNUSED, command: 8'hFF, rx_byte: 8'hFF});
		settle_block();
	endtask

	task automatic test_default_reply();
		send_start(8'h5A);
		send_reply(8'h5A, FLAW_NONE, 16'd2, 16'h8000, 0, 0);
		settle_block();
	endtask

	task automatic test_timeout();
		configure(8'h00, 8'h00, 8'h00, 16'd1);
		send_start(8'hFF);
		send_tick();
		settle_block();
	endtask

	task automatic test_restart_and_oversize();
		configure(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_start(8'h00);
		send_start(8'h3C);
		send_item('{opcode: OP_UNUSED, command: 8'h00, rx_byte: 8'h00});
		send_reply(8'h3C, FLAW_NONE, 16'hFFFF, 16'h7FFF, 0, 0);
		send_tick();
		settle_block();
	endtask

	task automatic run_random_transaction();
		logic [7:0]  cmd;
		logic [15:0] len;
		logic [15:0] temp;
		reply_flaw_e flaw;
		int          pick;
		int          junk;
		cmd = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			cmd = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		send_start(cmd);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(4, 16)) begin
				if ($urandom_range(0, 9) == 0) begin
					send_tick();
				end
				send_byte($urandom_range(0, 3) == 0 ? SYNC_BYTE : 8'($urandom_range(0, 255)));
			end
		end else begin
			pick = $urandom_range(0, 16);
			flaw = (pick <= 10) ? reply_flaw_e'(pick) : FLAW_NONE;
			case ($urandom_range(0, 19))
				0: len = 16'($urandom_range(0, 1));
				1: len = 16'($urandom_range(FRAME_LIMIT - 11, 65535));
				2: len = 16'($urandom_range(5, FRAME_LIMIT - 12));
				default: len = 16'($urandom_range(2, 4));
			endcase
			case ($urandom_range(0, 9))
				0: temp = 16'h8000;
				1: temp = 16'h7FFF;
				default: temp = 16'($urandom_range(0, 65535));
			endcase
			junk = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
			send_reply(cmd, flaw, len, temp, junk, 10);
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 1)) begin
					send_tick();
				end else begin
					send_byte(8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		logic [7:0]  regs[3];
		logic [15:0] tmo;
		for (int ph = 0; ph < 5; ph++) begin
			settle_block();
			if (ph == 4) begin
				idling_on = 1'b0;
			end
			for (int i = 0; i < 3; i++) begin
				case ($urandom_range(0, 3))
					0: regs[i] = 8'h00;
					1: regs[i] = 8'hFF;
					default: regs[i] = 8'($urandom_range(0, 255));
				endcase
			end
			case ($urandom_range(0, 5))
				0: tmo = 16'd1;
				1: tmo = 16'hFFFF;
				2: tmo = 16'd200;
				default: tmo = 16'($urandom_range(2, 30));
			endcase
			configure(regs[0], regs[1], regs[2], tmo);
			traffic_items = 0;
			while (traffic_items < 20) begin
				run_random_transaction();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_items();
		test_default_reply();
		test_timeout();
		test_restart_and_oversize();
		test_random_traffic();
		settle_block();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("sensor_frame_request_and_reply_check test passed");
		end else begin
			$display("sensor_frame_request_and_reply_check test failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("sensor_frame_request_and_reply_check test failed");
		$finish;
	end

endmodule
`default_nettype wire
